### rtl/lcmt_pkg.sv
`default_nettype none
package lcmt_pkg;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int OUT_W   = 49;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
  } line_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_CMP
  } state_t;

endpackage
`default_nettype wire

### rtl/lcmt_line_mem.sv
`default_nettype none
module lcmt_line_mem import lcmt_pkg::*; #(
  parameter int DEPTH = 131071,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire line_t         wr_line,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output line_t              rd_line
);

  line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_line;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_line <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/lcmt_eval.sv
`default_nettype none
module lcmt_eval import lcmt_pkg::*; #(
  parameter int XW = 17,
  localparam int PW = SLOPE_W + XW + 2,
  localparam int SW = ((PW > OUT_W) ? PW : OUT_W) + 1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [SLOPE_W:0] a,
  input  wire logic [XW-1:0]        x,
  input  wire logic signed [ICPT_W:0]  b,
  output logic signed [SW-1:0]      sum
);

  logic signed [PW-1:0]   prod;
  logic signed [ICPT_W:0] offs;

  // a*x + b, product registered before the add
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, x});
      offs <= b;
    end
  end

  assign sum = SW'(prod) + SW'(offs);

endmodule
`default_nettype wire

### rtl/li_chao_max_line_tree_core.sv
// Li Chao tree, max form, one line per node in a single-port-per-side memory.
// Walk: an item visits up to L = ceil(log2(DOMAIN_SIZE))+1 levels; at each level
// it reads the node, multiplies, then compares and writes back.
// A new item is taken only when idle; an out-of-range query answers 0 in the
// cycle after it is taken. The receiver cannot stall; done lasts one cycle.
// Reset: a clearing pass zeroes all 2*DOMAIN_SIZE-1 nodes, busy high.
`default_nettype none
module li_chao_max_line_tree_core import lcmt_pkg::*; #(
  parameter int DOMAIN_SIZE = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     cmd,
  input  wire logic signed [SLOPE_W-1:0] slope,
  input  wire logic signed [ICPT_W-1:0]  intercept,
  input  wire logic [16:0]              position,
  output logic                          done,
  output logic [OUT_W-1:0]              max_value
);

  localparam int XW    = $clog2(DOMAIN_SIZE + 1);
  localparam int DEPTH = 2 * DOMAIN_SIZE - 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PW    = SLOPE_W + XW + 2;
  localparam int SW    = ((PW > OUT_W) ? PW : OUT_W) + 1;

  localparam logic signed [SW-1:0] OUT_MAX_SW = {{(SW-OUT_W){1'b0}}, {OUT_W{1'b1}}};

  state_t state, state_next;

  logic [IDX_W-1:0] clr_cnt;
  logic [IDX_W-1:0] idx;
  logic [XW-1:0]    lo, hi, qx;
  logic             is_query;
  line_t            carry;
  logic signed [SW-1:0] best;

  // memory and eval hookup
  logic             mem_wr_en, mem_rd_en, eval_en;
  logic [IDX_W-1:0] mem_wr_addr;
  line_t            mem_wr_line, stored;
  logic signed [SLOPE_W:0] ev_a;
  logic [XW-1:0]           ev_x;
  logic signed [ICPT_W:0]  ev_b;
  logic signed [SW-1:0]    ev_sum;

  // walk decisions
  logic [XW:0]      lh_sum;
  logic [XW-1:0]    mid, span;
  logic             leaf, win, go_left, accept, out_of_range;
  logic signed [SW-1:0] best_new;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign out_of_range = (position == 17'd0) || (32'(position) > 32'(DOMAIN_SIZE));

  assign lh_sum = {1'b0, lo} + {1'b0, hi};
  assign mid    = lh_sum[XW:1];
  assign span   = mid - lo + 1'b1;
  assign leaf   = (lo >= hi);

  lcmt_line_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_line (mem_wr_line),
    .rd_en   (mem_rd_en),
    .rd_addr (idx),
    .rd_line (stored)
  );

  // insert: (carried - stored) at mid; query: stored at position
  always_comb begin
    if (is_query) begin
      ev_a = {stored.slope[SLOPE_W-1], stored.slope};
      ev_x = qx;
      ev_b = {stored.intercept[ICPT_W-1], stored.intercept};
    end else begin
      ev_a = {carry.slope[SLOPE_W-1], carry.slope}
             - {stored.slope[SLOPE_W-1], stored.slope};
      ev_x = mid;
      ev_b = {carry.intercept[ICPT_W-1], carry.intercept}
             - {stored.intercept[ICPT_W-1], stored.intercept};
    end
  end

  lcmt_eval #(.XW(XW)) u_eval (
    .clk (clk),
    .en  (eval_en),
    .a   (ev_a),
    .x   (ev_x),
    .b   (ev_b),
    .sum (ev_sum)
  );

  always_comb begin
    win      = !ev_sum[SW-1] && (ev_sum != '0);
    best_new = (ev_sum > best) ? ev_sum : best;
    if (is_query) begin
      go_left = (qx <= mid);
    end else if (win) begin
      go_left = (carry.slope > stored.slope);
    end else begin
      go_left = !(carry.slope > stored.slope);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == IDX_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && !(cmd == CMD_QUERY && out_of_range)) state_next = ST_READ;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_CMP;
      ST_CMP: begin
        state_next = leaf ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx;
    mem_wr_line = carry;
    mem_rd_en   = 1'b0;
    eval_en     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt;
        mem_wr_line = '0;
      end
      ST_READ: mem_rd_en = 1'b1;
      ST_MUL:  eval_en   = 1'b1;
      ST_CMP:  mem_wr_en = !is_query && win;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      done <= (accept && cmd == CMD_QUERY && out_of_range)
              || (state == ST_CMP && is_query && leaf);
    end
  end

  // walk registers and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      is_query        <= (cmd == CMD_QUERY);
      carry.slope     <= slope;
      carry.intercept <= intercept;
      qx              <= XW'(position);
      lo              <= XW'(1);
      hi              <= XW'(DOMAIN_SIZE);
      idx             <= '0;
      best            <= '0;
      max_value       <= '0;
    end else if (state == ST_CMP) begin
      if (!is_query && win) begin
        carry <= stored;   // loser moves down
      end
      if (is_query) begin
        best <= best_new;
        if (leaf) begin
          max_value <= (best_new > OUT_MAX_SW) ? {OUT_W{1'b1}} : best_new[OUT_W-1:0];
        end
      end
      if (!leaf) begin
        if (go_left) begin
          idx <= idx + 1'b1;
          hi  <= mid;
        end else begin
          idx <= idx + IDX_W'({span, 1'b0});
          lo  <= mid + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
